@@ design/caa_pkg.sv @@
// Package for the checkpointed arena allocator: payload structs, operation and
// status codes, controller state and the control struct between the controller
// and the datapath. No dependencies.
`default_nettype none

package caa_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  block_index;
    logic [15:0] offset;
    logic [2:0]  status;
  } out_item_t;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_MARK    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_RESTORE = 3'd1;
  localparam logic [2:0] ST_NO_BLOCKS   = 3'd2;
  localparam logic [2:0] ST_STACK_FULL  = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd4;

  localparam logic [16:0] RESET_BLOCK_SIZE = 17'h08000;
  localparam logic [16:0] SIZE_LIMIT       = 17'h10000;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ design/checkpointed_arena_allocator.sv @@
// Flow: a transferred item is registered, then executed into the output register
// once that register is free or being emptied; until then it waits in the controller.
// A new item is taken only after the previous one has executed; the execute step
// uses the registered read of the mark stack memory. Configuration is taken any cycle.
// Reset is synchronous, active low: block count 1, used offset 0, stack empty.
// Depends on caa_pkg, caa_ctrl, caa_dpath and caa_ram.
`default_nettype none

module checkpointed_arena_allocator #(
  parameter int MAX_BLOCKS       = 256,
  parameter int CHECKPOINT_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire caa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output caa_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [16:0]        cfg_data
);

  caa_pkg::cmd_t  cmd;
  caa_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  caa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  caa_dpath #(
    .MAX_BLOCKS       (MAX_BLOCKS),
    .CHECKPOINT_DEPTH (CHECKPOINT_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

@@ design/caa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module caa_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/caa_ctrl.sv @@
// Controller state machine: accepts one item, then issues its execute step
// once the output register can take the result. Depends on caa_pkg.
`default_nettype none

module caa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire caa_pkg::stat_t stat,
  output caa_pkg::cmd_t       cmd
);

  caa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= caa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      caa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = caa_pkg::S_EXEC;
        end
      end
      caa_pkg::S_EXEC: begin
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_nxt   = caa_pkg::S_IDLE;
        end
      end
      default: state_nxt = caa_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ design/caa_dpath.sv @@
// Datapath: block size register, arena state, mark stack memory and output
// register. Depends on caa_pkg and caa_ram.
`default_nettype none

module caa_dpath #(
  parameter int MAX_BLOCKS       = 256,
  parameter int CHECKPOINT_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire caa_pkg::in_item_t  in_data,
  input  wire logic               cfg_valid,
  input  wire logic [16:0]        cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output caa_pkg::out_item_t      out_data,
  input  wire caa_pkg::cmd_t      cmd,
  output caa_pkg::stat_t          stat
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int MW = $clog2(CHECKPOINT_DEPTH + 1);
  localparam int AW = (CHECKPOINT_DEPTH > 1) ? $clog2(CHECKPOINT_DEPTH) : 1;
  localparam int EW = CW + 16;

  caa_pkg::in_item_t  item_r;
  caa_pkg::out_item_t out_data_r, result;
  logic               out_valid_r;
  logic [16:0]        block_size_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [15:0]        used_r, used_nxt;
  logic [MW-1:0]      marks_r, marks_nxt;

  logic [16:0]   size, len17, sum;
  logic [EW-1:0] top, push_entry;
  logic [CW-1:0] top_count, cur_idx, top_idx;
  logic [15:0]   top_used;
  logic [MW-1:0] top_slot;
  logic          wr_en;

  assign size       = (block_size_r > caa_pkg::SIZE_LIMIT) ? caa_pkg::SIZE_LIMIT : block_size_r;
  assign len17      = {1'b0, item_r.length};
  assign sum        = {1'b0, used_r} + len17;
  assign top_count  = top[EW-1:16];
  assign top_used   = top[15:0];
  assign cur_idx    = count_r - CW'(1);
  assign top_idx    = top_count - CW'(1);
  assign top_slot   = marks_r - MW'(1);
  assign push_entry = {count_r, used_r};

  caa_ram #(
    .WIDTH (EW),
    .DEPTH (CHECKPOINT_DEPTH)
  ) u_marks (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (marks_r[AW-1:0]),
    .wr_data (push_entry),
    .rd_addr (top_slot[AW-1:0]),
    .rd_data (top)
  );

  always_comb begin
    count_nxt          = count_r;
    used_nxt           = used_r;
    marks_nxt          = marks_r;
    wr_en              = 1'b0;
    result.block_index = 8'(cur_idx);
    result.offset      = used_r;
    result.status      = caa_pkg::ST_OK;
    if (cmd.execute) begin
      unique case (item_r.operation)
        caa_pkg::OP_ALLOC: begin
          if (len17 >= size) begin
            result.status = caa_pkg::ST_TOO_LARGE;
          end else if (sum >= size) begin
            if (count_r >= CW'(MAX_BLOCKS)) begin
              result.status = caa_pkg::ST_NO_BLOCKS;
            end else begin
              count_nxt          = count_r + CW'(1);
              used_nxt           = item_r.length;
              result.block_index = 8'(count_r);
              result.offset      = 16'd0;
            end
          end else begin
            used_nxt = sum[15:0];
          end
        end
        caa_pkg::OP_MARK: begin
          if (marks_r >= MW'(CHECKPOINT_DEPTH)) begin
            result.status = caa_pkg::ST_STACK_FULL;
          end else begin
            wr_en     = 1'b1;
            marks_nxt = marks_r + MW'(1);
          end
        end
        caa_pkg::OP_RELEASE: begin
          if (marks_r == '0 || top_count > count_r) begin
            result.status = caa_pkg::ST_BAD_RESTORE;
          end else begin
            count_nxt          = top_count;
            used_nxt           = top_used;
            marks_nxt          = top_slot;
            result.block_index = 8'(top_idx);
            result.offset      = top_used;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= caa_pkg::RESET_BLOCK_SIZE;
      count_r      <= CW'(1);
      used_r       <= '0;
      marks_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        block_size_r <= cfg_data;
      end
      count_r <= count_nxt;
      used_r  <= used_nxt;
      marks_r <= marks_nxt;
      if (cmd.execute) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.execute) begin
      out_data_r <= result;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

`default_nettype wire

@@ design/caa_checker.sv @@
// Port-level checks for the checkpointed arena allocator, bound to the top level.
// Depends on caa_pkg.
`default_nettype none

module caa_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire caa_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("no result two cycles after transfer");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind checkpointed_arena_allocator caa_checker u_caa_checker (.*);

`default_nettype wire

@@ tb/tb_checkpointed_arena_allocator.sv @@
// Self-checking testbench for checkpointed_arena_allocator: directed table, then random
// mark / allocate / release sequences over several block sizes, checked against a predictor.
// Depends on caa_pkg and the checkpointed_arena_allocator RTL.
module tb_checkpointed_arena_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOCKS       = 256;
  localparam int CHECKPOINT_DEPTH = 16;
  localparam int HOLD_CYCLES      = 150;
  localparam logic [1:0] OP_NONE  = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [15:0]        len;
    int                 reps;
    bit                 pinned;
    caa_pkg::out_item_t want;
  } script_row_t;

  typedef struct {
    bit                 pinned;
    caa_pkg::out_item_t want;
  } pin_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  caa_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  caa_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [16:0]        cfg_data = '0;

  // predictor state
  logic [16:0] arena_size = caa_pkg::RESET_BLOCK_SIZE;
  int          arena_blocks = 1;
  int          arena_used = 0;
  int          mark_blocks [CHECKPOINT_DEPTH];
  int          mark_used [CHECKPOINT_DEPTH];
  int          mark_depth = 0;

  caa_pkg::out_item_t pending_results [$];
  pin_t               pinned_q [$];
  int                 items_sent = 0;
  int                 results_seen = 0;
  int                 mismatches = 0;

  // sender state
  logic [16:0] drive_size = caa_pkg::RESET_BLOCK_SIZE;
  int          marks_held = 0;
  int          burst_left = 0;

  // receiver state
  bit          hold_off_req = 1'b0;
  int          hold_count = 0;
  int          ready_mode = 0;
  int          mode_left = 0;
  logic [7:0]  ready_mask = 8'hFF;

  script_row_t script [12] = '{
    '{OP_NONE,             16'hFFFF, 1,  1'b1, '{8'd0, 16'd0, caa_pkg::ST_OK}},
    '{caa_pkg::OP_RELEASE, 16'h0000, 1,  1'b1, '{8'd0, 16'd0, caa_pkg::ST_BAD_RESTORE}},
    '{caa_pkg::OP_ALLOC,   16'hFFFF, 1,  1'b1, '{8'd0, 16'd0, caa_pkg::ST_TOO_LARGE}},
    '{caa_pkg::OP_ALLOC,   16'h8000, 1,  1'b1, '{8'd0, 16'd0, caa_pkg::ST_TOO_LARGE}},
    '{caa_pkg::OP_ALLOC,   16'h7FFF, 1,  1'b1, '{8'd0, 16'd0, caa_pkg::ST_OK}},
    '{caa_pkg::OP_ALLOC,   16'h0001, 1,  1'b1, '{8'd1, 16'd0, caa_pkg::ST_OK}},
    '{caa_pkg::OP_ALLOC,   16'h0000, 1,  1'b1, '{8'd1, 16'd1, caa_pkg::ST_OK}},
    '{caa_pkg::OP_MARK,    16'h0000, 1,  1'b1, '{8'd1, 16'd1, caa_pkg::ST_OK}},
    '{caa_pkg::OP_ALLOC,   16'h7FFF, 1,  1'b1, '{8'd2, 16'd0, caa_pkg::ST_OK}},
    '{caa_pkg::OP_RELEASE, 16'h0000, 1,  1'b1, '{8'd1, 16'd1, caa_pkg::ST_OK}},
    '{caa_pkg::OP_MARK,    16'h5555, 16, 1'b0, '{8'd0, 16'd0, caa_pkg::ST_OK}},
    '{caa_pkg::OP_MARK,    16'hAAAA, 1,  1'b1, '{8'd1, 16'd1, caa_pkg::ST_STACK_FULL}}
  };

  logic [16:0] size_plan [10] = '{
    17'd2, 17'h10000, 17'h1FFFF, 17'd3, 17'd0, 17'd1, 17'h10001, 17'd0, 17'd977,
    caa_pkg::RESET_BLOCK_SIZE
  };

  checkpointed_arena_allocator #(
    .MAX_BLOCKS       (MAX_BLOCKS),
    .CHECKPOINT_DEPTH (CHECKPOINT_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic caa_pkg::out_item_t arena_advance(input caa_pkg::in_item_t it);
    caa_pkg::out_item_t r;
    int                 lim;
    int                 start;
    bit                 placed;
    lim    = (arena_size > caa_pkg::SIZE_LIMIT) ? int'(caa_pkg::SIZE_LIMIT)
                                                : int'(arena_size);
    start  = 0;
    placed = 1'b0;
    r      = '0;
    r.status = caa_pkg::ST_OK;
    case (it.operation)
      caa_pkg::OP_ALLOC: begin
        if (int'(it.length) >= lim) begin
          r.status = caa_pkg::ST_TOO_LARGE;
        end else if (arena_used + int'(it.length) >= lim) begin
          if (arena_blocks >= MAX_BLOCKS) begin
            r.status = caa_pkg::ST_NO_BLOCKS;
          end else begin
            arena_blocks++;
            arena_used = int'(it.length);
            placed = 1'b1;
          end
        end else begin
          start = arena_used;
          arena_used += int'(it.length);
          placed = 1'b1;
        end
      end
      caa_pkg::OP_MARK: begin
        if (mark_depth >= CHECKPOINT_DEPTH) begin
          r.status = caa_pkg::ST_STACK_FULL;
        end else begin
          mark_blocks[mark_depth] = arena_blocks;
          mark_used[mark_depth]   = arena_used;
          mark_depth++;
        end
      end
      caa_pkg::OP_RELEASE: begin
        if (mark_depth == 0) begin
          r.status = caa_pkg::ST_BAD_RESTORE;
        end else if (mark_blocks[mark_depth-1] > arena_blocks) begin
          r.status = caa_pkg::ST_BAD_RESTORE;
        end else begin
          mark_depth--;
          arena_blocks = mark_blocks[mark_depth];
          arena_used   = mark_used[mark_depth];
        end
      end
      default: ;
    endcase
    r.block_index = 8'(arena_blocks - 1);
    r.offset      = placed ? 16'(start) : 16'(arena_used);
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    caa_pkg::out_item_t want;
    caa_pkg::out_item_t calc;
    pin_t               tag;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) arena_size = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = pending_results.pop_front();
          if (out_data.block_index !== want.block_index)
            report($sformatf("result %0d block_index %0d, expected %0d", results_seen,
                             out_data.block_index, want.block_index));
          if (out_data.offset !== want.offset)
            report($sformatf("result %0d offset %0d, expected %0d", results_seen,
                             out_data.offset, want.offset));
          if (out_data.status !== want.status)
            report($sformatf("result %0d status %0d, expected %0d", results_seen,
                             out_data.status, want.status));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        calc = arena_advance(in_data);
        tag  = pinned_q.pop_front();
        pending_results.insert(pending_results.size(), tag.pinned ? tag.want : calc);
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_req && hold_count < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_count++;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 80);
        ready_mask = 8'($urandom);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 4) == 0);
        default: begin
          out_ready <= ready_mask[0];
          ready_mask = {ready_mask[0], ready_mask[7:1]};
        end
      endcase
    end
  end

  task automatic put_item(input logic [1:0] op, input logic [15:0] len,
                          input bit pinned = 1'b0, input caa_pkg::out_item_t want = '0);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    pinned_q.insert(pinned_q.size(), pin_t'{pinned, want});
    in_valid <= 1'b1;
    in_data  <= {op, len};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (op == caa_pkg::OP_MARK && marks_held < CHECKPOINT_DEPTH) marks_held++;
    if (op == caa_pkg::OP_RELEASE && marks_held > 0) marks_held--;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic set_block_size(input logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    drive_size = v;
  endtask

  // lean_top favours the largest length that still fits, which opens a block almost every time
  function automatic logic [15:0] pick_length(input bit lean_top);
    int eff;
    int top;
    eff = (drive_size > caa_pkg::SIZE_LIMIT) ? int'(caa_pkg::SIZE_LIMIT) : int'(drive_size);
    top = (eff > 0) ? eff - 1 : 0;
    if (lean_top && $urandom_range(0, 15) != 0) return 16'(top);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'(top);
      2: return 16'($urandom);
      3: return (eff > 65535) ? 16'hFFFF : 16'(eff);
      4: return 16'($urandom_range(0, top / 64));
      default: return 16'($urandom_range(0, top));
    endcase
  endfunction

  task automatic run_phase(input int budget, input bit fill);
    int         stop_at;
    int         kind;
    int         floor_depth;
    logic [1:0] op;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      kind = fill ? 0 : $urandom_range(0, 29);
      fill = 1'b0;
      if (kind == 0) begin
        put_item(caa_pkg::OP_MARK, 16'($urandom));
        repeat ($urandom_range(270, 330)) put_item(caa_pkg::OP_ALLOC, pick_length(1'b1));
        put_item(caa_pkg::OP_RELEASE, 16'($urandom));
      end else if (kind == 1) begin
        floor_depth = marks_held;
        repeat (CHECKPOINT_DEPTH - marks_held + $urandom_range(1, 3))
          put_item(caa_pkg::OP_MARK, 16'($urandom));
        while (marks_held > floor_depth) put_item(caa_pkg::OP_RELEASE, 16'($urandom));
      end else if (kind < 20) begin
        put_item(caa_pkg::OP_MARK, 16'($urandom));
        repeat ($urandom_range(0, 8))
          put_item(($urandom_range(0, 9) == 0) ? OP_NONE : caa_pkg::OP_ALLOC,
                   pick_length(1'b0));
        put_item(caa_pkg::OP_RELEASE, 16'($urandom));
      end else begin
        op = 2'($urandom_range(0, 3));
        // keep the bottom mark so the block count can always be wound back
        if (op == caa_pkg::OP_RELEASE && marks_held <= 1) op = caa_pkg::OP_ALLOC;
        put_item(op, pick_length(1'b0));
      end
    end
  endtask

  initial begin : stimulus
    logic [16:0] sz;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      repeat (script[i].reps)
        put_item(script[i].op, script[i].len, script[i].pinned, script[i].want);

    foreach (size_plan[p]) begin
      while (marks_held > 1) put_item(caa_pkg::OP_RELEASE, 16'($urandom));
      if (marks_held == 0) put_item(caa_pkg::OP_MARK, 16'($urandom));
      drain_results();
      sz = (p == 7) ? 17'($urandom_range(2, 65536)) : size_plan[p];
      set_block_size(sz);
      if (p == 1) hold_off_req = 1'b1;
      run_phase(80, (p == 0 || p == 2));
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_checkpointed_arena_allocator: PASS");
    else
      $display("tb_checkpointed_arena_allocator: FAIL");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_checkpointed_arena_allocator: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
design/caa_pkg.sv
design/caa_ram.sv
design/caa_ctrl.sv
design/caa_dpath.sv
design/checkpointed_arena_allocator.sv
design/caa_checker.sv
tb/tb_checkpointed_arena_allocator.sv
